### hw/rtl/gag_pkg.sv
// shared types, constants and helper functions of the block gather address generator
// no dependencies; used by every module of the block
`default_nettype none

package gag_pkg;

   // widths of configuration, input and address
   localparam int SIZE_BITS    = 16;
   localparam int ADDRESS_BITS = 64;
   localparam int NDIM         = 4;
   localparam int DIM_W        = $clog2(NDIM);
   localparam int IN_W         = 32;

   // stream and register port widths
   localparam int REQ_DATA_W  = 2 * IN_W;
   localparam int RSP_DATA_W  = ((ADDRESS_BITS + 2 + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 4;

   // serial divider used at setup time
   localparam int DIV_N  = IN_W + SIZE_BITS;
   localparam int DIV_CW = $clog2(DIV_N);
   localparam int NJOBS  = 3 * NDIM;
   localparam int JOB_W  = $clog2(NJOBS);

   // reciprocal, shift and count widths
   localparam int REC_W    = IN_W + 1;
   localparam int SH_W     = $clog2(SIZE_BITS);
   localparam int PROD_W   = IN_W + REC_W;
   localparam int CNT_W    = IN_W + 1;
   localparam int STRIDE_W = 64;
   localparam int HALF_W   = STRIDE_W / 2;

   // counts saturate here, above any 32-bit input
   localparam logic [CNT_W-1:0] COUNT_CAP = {1'b1, {IN_W{1'b0}}};

   typedef logic [SIZE_BITS-1:0] size_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_SIZE   = 2'd1,
      STAT_BLOCK  = 2'd2,
      STAT_OFFSET = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SU_IDLE,
      SU_LOAD,
      SU_DIV,
      SU_MUL
   } setup_state_type;

   // derived configuration handed from setup to front and back
   typedef struct packed {
      logic                                 ready;
      logic                                 bad_size;
      logic [CNT_W-1:0]                     total_blocks;
      logic [CNT_W-1:0]                     tile_elems;
      size_type [NDIM-1:0]                  nblk;
      size_type [NDIM-1:0]                  tile;
      logic [NDIM-1:0][REC_W-1:0]           rec_nblk;
      logic [NDIM-1:0][REC_W-1:0]           rec_tile;
      logic [NDIM-1:0][SH_W-1:0]            sh_nblk;
      logic [NDIM-1:0][SH_W-1:0]            sh_tile;
      logic [NDIM-1:0][STRIDE_W-1:0]        stride;
   } cfg_type;

   // one classified item in the queue
   typedef struct packed {
      status_type       status;
      logic [IN_W-1:0]  blk;
      logic [IN_W-1:0]  off;
   } entry_type;

   // item as it moves down the divide levels
   typedef struct packed {
      status_type           status;
      logic [IN_W-1:0]      bx;
      logic [IN_W-1:0]      ex;
      size_type [NDIM-1:0]  bc;
      size_type [NDIM-1:0]  ec;
   } item_type;

   // position of the leading one
   function automatic logic [SH_W-1:0] msb_index(input size_type d);
      logic [SH_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SIZE_BITS; i++) begin
         if (d[i]) idx = i[SH_W-1:0];
      end
      return idx;
   endfunction

   // product clipped at the count cap
   function automatic logic [CNT_W-1:0] sat_mul(input logic [CNT_W-1:0] a, input size_type b);
      logic [CNT_W+SIZE_BITS-1:0] p;
      p = a * b;
      if (p > (CNT_W+SIZE_BITS)'(COUNT_CAP)) return COUNT_CAP;
      return p[CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/gag_setup.sv
// configuration registers and setup sequencer deriving block counts,
// reciprocals and strides; depends on gag_pkg
`default_nettype none

module gag_setup (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [gag_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gag_pkg::SIZE_BITS-1:0]   csr_data,
   output gag_pkg::cfg_type                     cfg
);
   import gag_pkg::*;

   setup_state_type state_ff, state_in;

   size_type [NDIM-1:0]        data_ff, tile_ff, nblk_ff;
   logic [NDIM-1:0][REC_W-1:0] rec_nblk_ff, rec_tile_ff;
   logic [NDIM-1:0][SH_W-1:0]  sh_nblk_ff, sh_tile_ff;
   logic [NDIM-1:0][STRIDE_W-1:0] stride_ff;

   logic [JOB_W-1:0]  job_ff;
   logic [DIV_CW-1:0] bit_ff;
   logic [1:0]        mul_ff;
   size_type          rem_ff, dsr_ff;
   logic [DIV_N-1:0]  quo_ff, dvd_ff;
   logic [SH_W-1:0]   sh_ff;
   logic              bad_ff;
   logic [CNT_W-1:0]  tb_ff, te_ff;
   logic [2*SIZE_BITS-1:0] pr_ff;
   logic [HALF_W+SIZE_BITS-1:0] plo_ff, phi_ff;

   logic               wr;
   logic [DIM_W-1:0]   jd;
   logic [1:0]         jg;
   logic [SIZE_BITS:0] rem_sh;
   logic               ge;
   size_type           rem_nx;
   logic [DIV_N-1:0]   quo_nx;
   logic               div_last;
   size_type           ld_dsr;
   logic [SH_W-1:0]    ld_sh;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign jd        = job_ff[DIM_W-1:0];
   assign jg        = 2'(job_ff >> DIM_W);

   // one restoring step a cycle
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[bit_ff]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      rem_nx = ge ? SIZE_BITS'(rem_sh - {1'b0, dsr_ff}) : rem_sh[SIZE_BITS-1:0];
      quo_nx = quo_ff;
      quo_nx[bit_ff] = ge;
      div_last = (bit_ff == '0);
   end

   // divisor for the current job
   always_comb begin
      ld_dsr = (jg == 2'd2) ? nblk_ff[jd] : tile_ff[jd];
      ld_sh  = msb_index(ld_dsr);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= SU_LOAD;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SU_IDLE: state_in = SU_IDLE;
         SU_LOAD: state_in = SU_DIV;
         SU_DIV: begin
            if (div_last) state_in = (job_ff == JOB_W'(NJOBS - 1)) ? SU_MUL : SU_LOAD;
         end
         SU_MUL: begin
            if (mul_ff == 2'd3) state_in = SU_IDLE;
         end
         default: state_in = SU_IDLE;
      endcase
      if (wr) state_in = SU_LOAD;
   end

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NDIM; i++) begin
            data_ff[i] <= size_type'(1);
            tile_ff[i] <= size_type'(1);
         end
      end else if (wr) begin
         if (csr_index < CSR_INDEX_W'(NDIM)) data_ff[csr_index[DIM_W-1:0]] <= csr_data;
         else if (csr_index < CSR_INDEX_W'(2 * NDIM)) tile_ff[csr_index[DIM_W-1:0]] <= csr_data;
      end
   end

   // sequencer counters
   always_ff @(posedge clock) begin
      if (reset || wr) begin
         job_ff <= '0;
         mul_ff <= '0;
      end else begin
         if (state_ff == SU_DIV && div_last) job_ff <= job_ff + JOB_W'(1);
         if (state_ff == SU_MUL) mul_ff <= mul_ff + 2'd1;
         else mul_ff <= '0;
      end
   end

   // divider and derived values
   always_ff @(posedge clock) begin
      case (state_ff)
         SU_LOAD: begin
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= DIV_CW'(DIV_N - 1);
            dsr_ff <= ld_dsr;
            sh_ff  <= ld_sh;
            if (job_ff == '0) bad_ff <= 1'b0;
            if (jg == 2'd0) dvd_ff <= DIV_N'(data_ff[jd]);
            else dvd_ff <= DIV_N'(1) << (DIV_CW'(IN_W) + DIV_CW'(ld_sh));
         end
         SU_DIV: begin
            rem_ff <= rem_nx;
            quo_ff <= quo_nx;
            bit_ff <= bit_ff - DIV_CW'(1);
            if (div_last) begin
               case (jg)
                  2'd0: begin
                     nblk_ff[jd] <= quo_nx[SIZE_BITS-1:0];
                     if (dsr_ff == '0 || rem_nx != '0) bad_ff <= 1'b1;
                  end
                  2'd1: begin
                     rec_tile_ff[jd] <= quo_nx[REC_W-1:0];
                     sh_tile_ff[jd]  <= sh_ff;
                  end
                  default: begin
                     rec_nblk_ff[jd] <= quo_nx[REC_W-1:0];
                     sh_nblk_ff[jd]  <= sh_ff;
                  end
               endcase
            end
         end
         SU_MUL: begin
            case (mul_ff)
               2'd0: begin
                  tb_ff <= CNT_W'(nblk_ff[0]);
                  te_ff <= CNT_W'(tile_ff[0]);
                  pr_ff <= data_ff[2] * data_ff[3];
                  stride_ff[3] <= STRIDE_W'(1);
                  stride_ff[2] <= STRIDE_W'(data_ff[3]);
               end
               2'd1: begin
                  tb_ff <= sat_mul(tb_ff, nblk_ff[1]);
                  te_ff <= sat_mul(te_ff, tile_ff[1]);
                  stride_ff[1] <= STRIDE_W'(pr_ff);
               end
               2'd2: begin
                  tb_ff  <= sat_mul(tb_ff, nblk_ff[2]);
                  te_ff  <= sat_mul(te_ff, tile_ff[2]);
                  plo_ff <= stride_ff[1][HALF_W-1:0] * data_ff[1];
                  phi_ff <= stride_ff[1][STRIDE_W-1:HALF_W] * data_ff[1];
               end
               default: begin
                  tb_ff <= sat_mul(tb_ff, nblk_ff[3]);
                  te_ff <= sat_mul(te_ff, tile_ff[3]);
                  stride_ff[0] <= STRIDE_W'(plo_ff) + {phi_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               end
            endcase
         end
         default: ;
      endcase
   end

   // derived configuration out
   always_comb begin
      cfg.ready        = (state_ff == SU_IDLE);
      cfg.bad_size     = bad_ff;
      cfg.total_blocks = tb_ff;
      cfg.tile_elems   = te_ff;
      cfg.nblk         = nblk_ff;
      cfg.tile         = tile_ff;
      cfg.rec_nblk     = rec_nblk_ff;
      cfg.rec_tile     = rec_tile_ff;
      cfg.sh_nblk      = sh_nblk_ff;
      cfg.sh_tile      = sh_tile_ff;
      cfg.stride       = stride_ff;
   end

endmodule

`default_nettype wire

### hw/rtl/gag_front.sv
// front end: accepts request beats and classifies them by status
// depends on gag_pkg
`default_nettype none

module gag_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [gag_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire gag_pkg::cfg_type               cfg,
   output logic                                fq_valid,
   output gag_pkg::entry_type                  fq_entry,
   input  wire logic                           fq_ready
);
   import gag_pkg::*;

   logic      fr_valid_ff;
   entry_type fr_entry_ff, fr_entry_in;
   logic      acc;

   assign req_tready = cfg.ready && (!fr_valid_ff || fq_ready);
   assign acc        = req_tvalid && req_tready;
   assign fq_valid   = fr_valid_ff;
   assign fq_entry   = fr_entry_ff;

   // status check in priority order
   always_comb begin
      fr_entry_in.blk = req_tdata[IN_W-1:0];
      fr_entry_in.off = req_tdata[2*IN_W-1:IN_W];
      if (cfg.bad_size) fr_entry_in.status = STAT_SIZE;
      else if (CNT_W'(fr_entry_in.blk) >= cfg.total_blocks) fr_entry_in.status = STAT_BLOCK;
      else if (CNT_W'(fr_entry_in.off) >= cfg.tile_elems) fr_entry_in.status = STAT_OFFSET;
      else fr_entry_in.status = STAT_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) fr_valid_ff <= 1'b0;
      else if (acc) fr_valid_ff <= 1'b1;
      else if (fq_ready) fr_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (acc) fr_entry_ff <= fr_entry_in;
   end

endmodule

`default_nettype wire

### hw/rtl/gag_queue.sv
// short queue between front and back end
// depends on gag_pkg
`default_nettype none

module gag_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire gag_pkg::entry_type push_entry,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output gag_pkg::entry_type      pop_entry
);
   import gag_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] head_ff, tail_ff;
   logic [QPTR_W:0]   count_ff;
   logic              push, pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[head_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[tail_ff] <= push_entry;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) tail_ff <= tail_ff + QPTR_W'(1);
         if (pop)  head_ff <= head_ff + QPTR_W'(1);
         if (push && !pop) count_ff <= count_ff + (QPTR_W+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (QPTR_W+1)'(1);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/gag_back.sv
// back end: pipelined reciprocal divides, coordinate merge and address sum
// depends on gag_pkg
`default_nettype none

module gag_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire gag_pkg::entry_type             in_entry,
   input  wire gag_pkg::cfg_type               cfg,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [gag_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import gag_pkg::*;

   localparam int NLVL = NDIM - 1;

   logic     en;
   logic     lv_valid [NLVL+1];
   item_type lv_item  [NLVL+1];

   assign en       = !rsp_tvalid || rsp_tready;
   assign in_ready = en;

   // item entering the first level
   assign lv_valid[0] = in_valid;
   assign lv_item[0]  = '{status: in_entry.status, bx: in_entry.blk, ex: in_entry.off,
                          bc: '0, ec: '0};

   // one divide level for each dimension but the last: multiply, estimate, correct
   for (genvar j = 0; j < NLVL; j++) begin : g_lvl
      logic                a_valid_ff, b_valid_ff, c_valid_ff;
      item_type            a_item_ff, b_item_ff, c_item_ff, c_item_in;
      logic [PROD_W-1:0]   a_pb_ff, a_pe_ff;
      logic [IN_W-1:0]     b_qb_ff, b_qe_ff, b_rb_ff, b_re_ff;
      logic [IN_W-1:0]     qb_w, qe_w;
      logic [IN_W+SIZE_BITS-1:0] mb_w, me_w;
      size_type            db, de;
      logic                geb, gee;

      assign db = cfg.nblk[j];
      assign de = cfg.tile[NDIM-1-j];

      // quotient estimate and raw remainder
      always_comb begin
         qb_w = IN_W'(a_pb_ff >> (IN_W + int'(cfg.sh_nblk[j])));
         qe_w = IN_W'(a_pe_ff >> (IN_W + int'(cfg.sh_tile[NDIM-1-j])));
         mb_w = qb_w * db;
         me_w = qe_w * de;
      end

      // one correction step
      always_comb begin
         geb = b_rb_ff >= IN_W'(db);
         gee = b_re_ff >= IN_W'(de);
         c_item_in = b_item_ff;
         c_item_in.bx = b_qb_ff + IN_W'(geb);
         c_item_in.ex = b_qe_ff + IN_W'(gee);
         c_item_in.bc[j] = SIZE_BITS'(geb ? b_rb_ff - IN_W'(db) : b_rb_ff);
         c_item_in.ec[NDIM-1-j] = SIZE_BITS'(gee ? b_re_ff - IN_W'(de) : b_re_ff);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff <= 1'b0;
            b_valid_ff <= 1'b0;
            c_valid_ff <= 1'b0;
         end else if (en) begin
            a_valid_ff <= lv_valid[j];
            b_valid_ff <= a_valid_ff;
            c_valid_ff <= b_valid_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_item_ff <= lv_item[j];
            a_pb_ff   <= lv_item[j].bx * cfg.rec_nblk[j];
            a_pe_ff   <= lv_item[j].ex * cfg.rec_tile[NDIM-1-j];
            b_item_ff <= a_item_ff;
            b_qb_ff   <= qb_w;
            b_qe_ff   <= qe_w;
            b_rb_ff   <= a_item_ff.bx - mb_w[IN_W-1:0];
            b_re_ff   <= a_item_ff.ex - me_w[IN_W-1:0];
            c_item_ff <= c_item_in;
         end
      end

      assign lv_valid[j+1] = c_valid_ff;
      assign lv_item[j+1]  = c_item_ff;
   end

   // coordinate, partial product, term, pair sum and output stages
   logic                k_valid_ff, p_valid_ff, t_valid_ff, s_valid_ff, o_valid_ff;
   status_type          k_stat_ff, p_stat_ff, t_stat_ff, s_stat_ff, o_stat_ff;
   size_type [NDIM-1:0] k_coord_ff, coord_in;
   logic [NDIM-1:0][HALF_W+SIZE_BITS-1:0] p_lo_ff, p_hi_ff;
   logic [NDIM-1:0][STRIDE_W-1:0] t_term_ff;
   logic [STRIDE_W-1:0] s_01_ff, s_23_ff, sum_w;
   logic [ADDRESS_BITS-1:0] o_addr_ff;
   logic [2*SIZE_BITS-1:0]  bt_w [NDIM];
   item_type            fin;

   // last coordinates are the leftover quotients
   always_comb begin
      fin = lv_item[NLVL];
      fin.bc[NDIM-1] = fin.bx[SIZE_BITS-1:0];
      fin.ec[0]      = fin.ex[SIZE_BITS-1:0];
      for (int i = 0; i < NDIM; i++) begin
         bt_w[i]     = fin.bc[i] * cfg.tile[i];
         coord_in[i] = bt_w[i][SIZE_BITS-1:0] + fin.ec[i];
      end
      sum_w = s_01_ff + s_23_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         k_valid_ff <= lv_valid[NLVL];
         p_valid_ff <= k_valid_ff;
         t_valid_ff <= p_valid_ff;
         s_valid_ff <= t_valid_ff;
         o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_stat_ff  <= fin.status;
         k_coord_ff <= coord_in;
         p_stat_ff  <= k_stat_ff;
         t_stat_ff  <= p_stat_ff;
         s_stat_ff  <= t_stat_ff;
         o_stat_ff  <= s_stat_ff;
         for (int i = 0; i < NDIM; i++) begin
            p_lo_ff[i]   <= k_coord_ff[i] * cfg.stride[i][HALF_W-1:0];
            p_hi_ff[i]   <= k_coord_ff[i] * cfg.stride[i][STRIDE_W-1:HALF_W];
            t_term_ff[i] <= STRIDE_W'(p_lo_ff[i]) + {p_hi_ff[i][HALF_W-1:0], {HALF_W{1'b0}}};
         end
         s_01_ff   <= t_term_ff[0] + t_term_ff[1];
         s_23_ff   <= t_term_ff[2] + t_term_ff[3];
         o_addr_ff <= (s_stat_ff == STAT_OK) ? sum_w[ADDRESS_BITS-1:0] : '0;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_stat_ff, o_addr_ff});

endmodule

`default_nettype wire

### hw/rtl/nd_block_gather_address_gen_core.sv
// top level of the block gather address generator: setup, front, queue, back
// depends on gag_pkg, gag_setup, gag_front, gag_queue and gag_back
//
// Turns a linear block number and an element offset inside that block into the
// row-major address of the element in an array of up to four dimensions, with a
// status (ok, size not a multiple of the block, block out of range, offset out of
// range; address zero unless ok). One beat is taken every cycle and results
// stream out at the same rate while rsp_tready stays high and setup is idle.
// After reset and after every register write a setup sequencer recomputes
// block counts, reciprocals and strides with one serial divider: 12 divides,
// each a load step then one restoring step per quotient bit, plus 4 multiply
// steps, while req_tready stays low. Register writes are always taken.
`default_nettype none

module nd_block_gather_address_gen_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: block_number [31:0], element_offset [63:32]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [gag_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response: source_address [ADDRESS_BITS-1:0], status above it, zero padded
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [gag_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gag_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gag_pkg::SIZE_BITS-1:0]   csr_data
);
   import gag_pkg::*;

   cfg_type   cfg;
   logic      fq_valid, fq_ready, bq_valid, bq_ready;
   entry_type fq_entry, bq_entry;

   gag_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .fq_valid   (fq_valid),
      .fq_entry   (fq_entry),
      .fq_ready   (fq_ready)
   );

   gag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_entry (fq_entry),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_entry  (bq_entry)
   );

   gag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bq_valid),
      .in_ready   (bq_ready),
      .in_entry   (bq_entry),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // no request beat while derived values are being rebuilt
   a_accept_ready: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> cfg.ready)
      else $error("request beat taken during setup");

   // a register write restarts setup and closes the request side
   a_write_stalls: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_tready)
      else $error("request side open right after a register write");

   // failed status always carries a zero address
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[ADDRESS_BITS +: 2] != STAT_OK)
         |-> (rsp_tdata[ADDRESS_BITS-1:0] == '0))
      else $error("nonzero address with error status");

endmodule

`default_nettype wire

### verif/nd_block_gather_address_gen_core_test.sv
// self-checking testbench for the block gather address generator core
// drives request and register beats, predicts each address and status, checks responses
// depends on gag_pkg and nd_block_gather_address_gen_core
`timescale 1ns / 1ps

module nd_block_gather_address_gen_core_test;
   import gag_pkg::*;

   localparam logic [63:0] CAP = 64'd1 << 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_BEAT = 200;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [63:0] addr;
      status_type  status;
   } gather_result_t;

   typedef struct {
      logic [31:0] blk;
      logic [31:0] off;
      bit          typed;
      logic [63:0] addr;
      status_type  status;
   } directed_row_t;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SIZE_BITS-1:0] csr_data;

   // predictor copy of the extents
   logic [63:0] data_dim [NDIM];
   logic [63:0] tile_dim [NDIM];

   gather_result_t pending_q [$];
   int errors = 0;
   int rsp_beats = 0;
   int req_beats = 0;
   int csr_beats = 0;
   int idle_cycles = 0;
   bit no_idle = 0;
   directed_row_t directed [$];

   nd_block_gather_address_gen_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // product clipped at the count cap
   function automatic logic [63:0] capped_product(logic [63:0] a, logic [63:0] b);
      if (a == 0 || b == 0) return 0;
      if (a > CAP / b) return CAP;
      return a * b;
   endfunction

   function automatic bit sizes_bad();
      for (int i = 0; i < NDIM; i++) begin
         if (tile_dim[i] == 0 || data_dim[i] % tile_dim[i] != 0) return 1;
      end
      return 0;
   endfunction

   // a zero block extent counts as no blocks
   function automatic logic [63:0] block_count();
      logic [63:0] n;
      n = 1;
      for (int i = 0; i < NDIM; i++)
         n = capped_product(n, (tile_dim[i] == 0) ? 64'd0 : data_dim[i] / tile_dim[i]);
      return n;
   endfunction

   function automatic logic [63:0] element_count();
      logic [63:0] n;
      n = 1;
      for (int i = 0; i < NDIM; i++) n = capped_product(n, tile_dim[i]);
      return n;
   endfunction

   // address and status of one element, from the current extents
   function automatic gather_result_t gather_address(logic [31:0] blk, logic [31:0] off);
      gather_result_t r;
      logic [63:0] b, o, nb, bc [NDIM], ec [NDIM];
      r.addr = 0;
      r.status = STAT_OK;
      if (sizes_bad()) begin
         r.status = STAT_SIZE;
         return r;
      end
      if (blk >= block_count()) begin
         r.status = STAT_BLOCK;
         return r;
      end
      if (off >= element_count()) begin
         r.status = STAT_OFFSET;
         return r;
      end
      // block coordinates, dimension 0 fastest
      b = blk;
      for (int i = 0; i < NDIM; i++) begin
         nb = data_dim[i] / tile_dim[i];
         bc[i] = b % nb;
         b = b / nb;
      end
      // element coordinates, dimension 3 fastest
      o = off;
      for (int i = NDIM - 1; i >= 0; i--) begin
         ec[i] = o % tile_dim[i];
         o = o / tile_dim[i];
      end
      for (int i = 0; i < NDIM; i++) r.addr = r.addr * data_dim[i] + bc[i] * tile_dim[i] + ec[i];
      return r;
   endfunction

   // one request beat; expectation queued at acceptance
   task automatic send_request(logic [31:0] blk, logic [31:0] off, bit typed = 0,
                               logic [63:0] eaddr = 0, status_type estat = STAT_OK);
      int gap;
      gather_result_t r;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {off, blk};
      do @(posedge clock); while (!req_tready);
      r = gather_address(blk, off);
      if (typed) begin
         r.addr = eaddr;
         r.status = estat;
      end
      pending_q.push_back(r);
      req_beats++;
      @(negedge clock);
   endtask

   // register write once the block has drained
   task automatic write_register(int idx, logic [15:0] value);
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx[CSR_INDEX_W-1:0];
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NDIM) data_dim[idx] = value;
      else if (idx < 2 * NDIM) tile_dim[idx - NDIM] = value;
      csr_beats++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic load_extents(logic [15:0] d0, d1, d2, d3, t0, t1, t2, t3);
      write_register(0, d0); write_register(1, d1);
      write_register(2, d2); write_register(3, d3);
      write_register(4, t0); write_register(5, t1);
      write_register(6, t2); write_register(7, t3);
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int gap;
      gather_result_t want;
      logic [63:0] got_addr;
      logic [1:0] got_stat;
      rsp_tready = 0;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 10);
         if (rsp_beats == HOLD_BEAT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         got_addr = rsp_tdata[63:0];
         got_stat = rsp_tdata[65:64];
         rsp_beats++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected beat addr %h status %0d", $time, got_addr, got_stat);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (got_addr !== want.addr) begin
               $display("%0t: address expected %h actual %h", $time, want.addr, got_addr);
               errors++;
            end
            if (got_stat !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got_stat);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d beats outstanding", $time, pending_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [63:0] nblocks, nelems;
      logic [31:0] blk, off;
      logic [15:0] t [NDIM], n [NDIM];
      int count;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < NDIM; i++) begin
         data_dim[i] = 1;
         tile_dim[i] = 1;
      end
      repeat (7) @(negedge clock);
      reset <= 0;

      // directed rows at the reset extents: one block of one element
      directed = '{
         '{32'd0, 32'd0, 1, 64'd0, STAT_OK},
         '{32'd1, 32'd0, 1, 64'd0, STAT_BLOCK},
         '{32'd0, 32'd1, 1, 64'd0, STAT_OFFSET},
         '{32'hFFFFFFFF, 32'hFFFFFFFF, 1, 64'd0, STAT_BLOCK},
         '{32'd0, 32'hFFFFFFFF, 1, 64'd0, STAT_OFFSET},
         '{32'h55555555, 32'hAAAAAAAA, 0, 64'd0, STAT_OK}
      };
      foreach (directed[i])
         send_request(directed[i].blk, directed[i].off, directed[i].typed,
                      directed[i].addr, directed[i].status);

      // phases: fixed extents first, then random ones
      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: load_extents(4, 6, 8, 10, 2, 3, 4, 5);
            1: load_extents(4, 6, 5, 10, 2, 3, 2, 5);
            2: load_extents(4, 6, 8, 10, 2, 3, 4, 0);
            3: load_extents(4, 0, 8, 10, 2, 1, 4, 5);
            4: load_extents(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1);
            5: load_extents(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            6: load_extents(1, 1, 1, 16'hFFFF, 1, 1, 1, 16'hFFFF);
            default: begin
               for (int i = 0; i < NDIM; i++) begin
                  t[i] = $urandom_range(1, 8);
                  n[i] = $urandom_range(1, 8);
               end
               if ($urandom_range(0, 3) == 0) begin
                  t[3] = $urandom_range(1, 255);
                  n[3] = $urandom_range(1, 255);
               end
               load_extents(t[0] * n[0], t[1] * n[1], t[2] * n[2],
                            t[3] * n[3] + (ph == 12), t[0], t[1], t[2], t[3]);
               // indexes past the list are ignored
               write_register($urandom_range(2 * NDIM, 15), $urandom);
            end
         endcase
         no_idle = (ph % 3 == 2);
         nblocks = block_count();
         nelems = element_count();
         // corners of the block and offset ranges
         send_request(0, 0);
         send_request(nblocks > 64'hFFFFFFFF ? 32'hFFFFFFFF : nblocks - 1,
                      nelems > 64'hFFFFFFFF ? 32'hFFFFFFFF : nelems - 1);
         send_request(nblocks[31:0], 0);
         send_request(0, nelems[31:0]);
         count = (ph < 7) ? 20 : 70;
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 8 && nblocks != 0 && nelems != 0) begin
               blk = nblocks > 64'hFFFFFFFF ? $urandom : $urandom_range(0, nblocks - 1);
               off = nelems > 64'hFFFFFFFF ? $urandom : $urandom_range(0, nelems - 1);
            end else begin
               blk = $urandom;
               off = $urandom;
            end
            send_request(blk, off);
         end
      end
      req_tvalid <= 0;

      while (pending_q.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d request beats, %0d response beats, %0d register writes",
               req_beats, rsp_beats, csr_beats);
      $display("extents: reset, fixed, non-multiple, zero block, zero array, extremes, random");
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
